// ===== rtl/pwmg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM generator package
// Shared constants, codes and the configuration struct.
// ----------------------------------------------------------------------------
package pwmg_pkg;

    localparam int DEF_COUNTER_WIDTH = 16;
    localparam int FULL_SCALE_SHIFT  = 15;   // duty 32768 is 100 percent
    localparam int FIELD_W           = 16;   // width of the item's value fields
    localparam int APB_ADDR_W        = 5;
    localparam int APB_DATA_W        = 32;
    localparam int ACT_W             = 2;
    localparam int ACTIONS_W         = 12;

    // item action codes
    localparam logic [ACT_W-1:0] ACT_TICK       = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET_DUTY   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET_PERIOD = 2'd2;

    // level action codes
    localparam logic [1:0] LVL_NONE   = 2'd0;
    localparam logic [1:0] LVL_TOGGLE = 2'd1;
    localparam logic [1:0] LVL_LOW    = 2'd2;
    localparam logic [1:0] LVL_HIGH   = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_CONTROL   = 3'd0;
    localparam logic [2:0] REG_ACTIONS_A = 3'd1;
    localparam logic [2:0] REG_ACTIONS_B = 3'd2;
    localparam logic [2:0] REG_OUT_EN    = 3'd3;
    localparam logic [2:0] REG_OUT_INV   = 3'd4;
    localparam logic [2:0] REG_PERIOD_VAR = 3'd5;

    typedef struct packed {
        logic                 run;
        logic                 up_down;
        logic [ACTIONS_W-1:0] actions_a;
        logic [ACTIONS_W-1:0] actions_b;
        logic [1:0]           out_en;
        logic [1:0]           out_inv;
        logic                 period_var;
    } t_cfg;

endpackage

// ===== rtl/pwmg_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM generator configuration registers
// APB register file: control, action tables, output enable/invert, period mode.
// ----------------------------------------------------------------------------
module pwmg_cfg
    import pwmg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [1:0]           r_control;
    logic [ACTIONS_W-1:0] r_actions_a;
    logic [ACTIONS_W-1:0] r_actions_b;
    logic [1:0]           r_out_en;
    logic [1:0]           r_out_inv;
    logic                 r_period_var;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control    <= '0;
            r_actions_a  <= '0;
            r_actions_b  <= '0;
            r_out_en     <= '0;
            r_out_inv    <= '0;
            r_period_var <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CONTROL:    r_control    <= pwdata[1:0];
                REG_ACTIONS_A:  r_actions_a  <= pwdata[ACTIONS_W-1:0];
                REG_ACTIONS_B:  r_actions_b  <= pwdata[ACTIONS_W-1:0];
                REG_OUT_EN:     r_out_en     <= pwdata[1:0];
                REG_OUT_INV:    r_out_inv    <= pwdata[1:0];
                REG_PERIOD_VAR: r_period_var <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CONTROL:    prdata = APB_DATA_W'(r_control);
            REG_ACTIONS_A:  prdata = APB_DATA_W'(r_actions_a);
            REG_ACTIONS_B:  prdata = APB_DATA_W'(r_actions_b);
            REG_OUT_EN:     prdata = APB_DATA_W'(r_out_en);
            REG_OUT_INV:    prdata = APB_DATA_W'(r_out_inv);
            REG_PERIOD_VAR: prdata = APB_DATA_W'(r_period_var);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.run        = r_control[0];
    assign o_cfg.up_down    = r_control[1];
    assign o_cfg.actions_a  = r_actions_a;
    assign o_cfg.actions_b  = r_actions_b;
    assign o_cfg.out_en     = r_out_en;
    assign o_cfg.out_inv    = r_out_inv;
    assign o_cfg.period_var = r_period_var;

endmodule

// ===== rtl/pwmg_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM generator duty scaler
// compare = duty * load / 32768, saturated at load.
// ----------------------------------------------------------------------------
module pwmg_scale
    import pwmg_pkg::*;
#(
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  logic [FIELD_W-1:0]       i_duty,
    input  logic [COUNTER_WIDTH-1:0] i_load,
    output logic [COUNTER_WIDTH-1:0] o_compare
);

    localparam int PROD_W = FIELD_W + COUNTER_WIDTH;
    localparam int QUOT_W = PROD_W - FULL_SCALE_SHIFT;

    logic [PROD_W-1:0] product;
    logic [QUOT_W-1:0] quotient;

    assign product  = PROD_W'(i_duty) * PROD_W'(i_load);
    assign quotient = product[PROD_W-1:FULL_SCALE_SHIFT];

    assign o_compare = (quotient > QUOT_W'(i_load)) ? i_load
                                                   : quotient[COUNTER_WIDTH-1:0];

endmodule

// ===== rtl/pwmg_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM generator core
// Counter, compare and level state; per-item update and result register.
// ----------------------------------------------------------------------------
module pwmg_gen
    import pwmg_pkg::*;
#(
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  logic [ACT_W-1:0]   i_action,
    input  logic               i_output_select,
    input  logic [FIELD_W-1:0] i_duty,
    input  logic [FIELD_W-1:0] i_period,
    output logic               o_advance,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_pwm_a,
    output logic               o_pwm_b,
    output logic [FIELD_W-1:0] o_counter_value,
    output logic [FIELD_W-1:0] o_compare_written,
    output logic               o_write_ignored
);

    logic [COUNTER_WIDTH-1:0] r_counter, n_counter;
    logic [COUNTER_WIDTH-1:0] r_load, n_load;
    logic [COUNTER_WIDTH-1:0] r_cmp_a, n_cmp_a;
    logic [COUNTER_WIDTH-1:0] r_cmp_b, n_cmp_b;
    logic                     r_level_a, n_level_a;
    logic                     r_level_b, n_level_b;
    logic                     r_up, n_up;

    logic               r_out_valid;
    logic               r_pwm_a, r_pwm_b, r_ignored;
    logic [FIELD_W-1:0] r_cnt_out, r_cmp_out;

    logic [COUNTER_WIDTH-1:0] period_cw;
    logic [COUNTER_WIDTH-1:0] scale_load;
    logic [COUNTER_WIDTH-1:0] scaled;
    logic [COUNTER_WIDTH-1:0] written;
    logic                     ignored;
    logic                     step_up;
    logic                     ev_zero, ev_load, ev_a, ev_b;

    // first non-none action in priority zero, load, cmpA, cmpB wins
    function automatic logic apply_events(
        input logic                 level,
        input logic [ACTIONS_W-1:0] acts,
        input logic                 ez,
        input logic                 el,
        input logic                 ea,
        input logic                 eb,
        input logic                 up
    );
        logic [1:0] ca;
        logic [1:0] cb;
        logic [1:0] code;
        logic       res;
        ca   = up ? acts[5:4] : acts[7:6];
        cb   = up ? acts[9:8] : acts[11:10];
        code = LVL_NONE;
        if (ez && acts[1:0] != LVL_NONE) begin
            code = acts[1:0];
        end else if (el && acts[3:2] != LVL_NONE) begin
            code = acts[3:2];
        end else if (ea && ca != LVL_NONE) begin
            code = ca;
        end else if (eb && cb != LVL_NONE) begin
            code = cb;
        end
        case (code)
            LVL_TOGGLE: res = ~level;
            LVL_LOW:    res = 1'b0;
            LVL_HIGH:   res = 1'b1;
            default:    res = level;
        endcase
        return res;
    endfunction

    assign o_advance = i_valid & (~r_out_valid | i_ready);

    assign period_cw  = COUNTER_WIDTH'(i_period);
    assign scale_load = (i_action == ACT_SET_PERIOD) ? period_cw : r_load;

    pwmg_scale #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_scale (
        .i_duty   (i_duty),
        .i_load   (scale_load),
        .o_compare(scaled)
    );

    always_comb begin
        n_counter = r_counter;
        n_load    = r_load;
        n_cmp_a   = r_cmp_a;
        n_cmp_b   = r_cmp_b;
        n_level_a = r_level_a;
        n_level_b = r_level_b;
        n_up      = r_up;
        written   = '0;
        ignored   = 1'b0;
        step_up   = 1'b0;
        ev_zero   = 1'b0;
        ev_load   = 1'b0;
        ev_a      = 1'b0;
        ev_b      = 1'b0;
        case (i_action)
            ACT_TICK: begin
                if (i_cfg.run) begin
                    if (!i_cfg.up_down) begin
                        n_counter = (r_counter == '0) ? r_load
                                                      : r_counter - COUNTER_WIDTH'(1);
                    end else if (r_up && r_counter < r_load) begin
                        step_up   = 1'b1;
                        n_counter = r_counter + COUNTER_WIDTH'(1);
                    end else if (r_up) begin
                        n_up      = 1'b0;
                        n_counter = (r_counter != '0) ? r_counter - COUNTER_WIDTH'(1) : '0;
                    end else if (r_counter != '0) begin
                        n_counter = r_counter - COUNTER_WIDTH'(1);
                    end else begin
                        // turn at zero; an empty period parks at zero
                        step_up   = 1'b1;
                        n_up      = 1'b1;
                        n_counter = (r_load != '0) ? COUNTER_WIDTH'(1) : '0;
                    end
                    ev_zero   = (n_counter == '0);
                    ev_load   = (n_counter == r_load);
                    ev_a      = (n_counter == r_cmp_a);
                    ev_b      = (n_counter == r_cmp_b);
                    n_level_a = apply_events(r_level_a, i_cfg.actions_a,
                                             ev_zero, ev_load, ev_a, ev_b, step_up);
                    n_level_b = apply_events(r_level_b, i_cfg.actions_b,
                                             ev_zero, ev_load, ev_a, ev_b, step_up);
                end
            end
            ACT_SET_DUTY, ACT_SET_PERIOD: begin
                if (!i_cfg.run || (i_action == ACT_SET_PERIOD && !i_cfg.period_var)) begin
                    ignored = 1'b1;
                end else begin
                    if (i_action == ACT_SET_PERIOD) begin
                        n_load = period_cw;
                    end
                    written = scaled;
                    if (i_output_select) begin
                        n_cmp_b = scaled;
                    end else begin
                        n_cmp_a = scaled;
                    end
                end
            end
            default: ;
        endcase
    end

    // state moves only when the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_load    <= '0;
            r_cmp_a   <= '0;
            r_cmp_b   <= '0;
            r_level_a <= 1'b0;
            r_level_b <= 1'b0;
            r_up      <= 1'b0;
        end else if (o_advance) begin
            r_counter <= n_counter;
            r_load    <= n_load;
            r_cmp_a   <= n_cmp_a;
            r_cmp_b   <= n_cmp_b;
            r_level_a <= n_level_a;
            r_level_b <= n_level_b;
            r_up      <= n_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_pwm_a   <= i_cfg.out_en[0] & (n_level_a ^ i_cfg.out_inv[0]);
            r_pwm_b   <= i_cfg.out_en[1] & (n_level_b ^ i_cfg.out_inv[1]);
            r_cnt_out <= FIELD_W'(n_counter);
            r_cmp_out <= FIELD_W'(written);
            r_ignored <= ignored;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_pwm_a           = r_pwm_a;
    assign o_pwm_b           = r_pwm_b;
    assign o_counter_value   = r_cnt_out;
    assign o_compare_written = r_cmp_out;
    assign o_write_ignored   = r_ignored;

endmodule

// ===== rtl/pwm_generator_with_duty_scaling.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM generator with duty scaling
// Two-output PWM generator driven by tick and duty/period items.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per tick or compare write. tuser carries the
//   action (tick, set duty, set period and duty) and the A/B select; tdata
//   carries duty and period. Master stream: one result item per input item
//   with both PWM levels, the counter, the compare written and an ignore flag.
//   APB port: control, action tables, output enable/invert, period mode;
//   write only while the stream is idle.
// Path: an accepted item sits in the input register; its result is
//   registered in the result register when the item advances.
// Throughput: one item per cycle unless the master side stalls. The
//   counter/compare update and the 16 x COUNTER_WIDTH duty multiply
//   run combinationally from the input register to the result register.
// Reset: counter, load, compares and levels clear, direction is down, all APB
//   registers clear except period mode, which resets to variable.
// Stall: when the master side holds tready low, the result register holds
//   and the input register keeps one more item, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module pwm_generator_with_duty_scaling
    import pwmg_pkg::*;
#(
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [15:0] duty, [31:16] period
    input  logic [2:0]            s_axis_tuser,   // [1:0] action, [2] output_select
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // [0] pwm_a, [1] pwm_b,
                                                  // [17:2] counter_value,
                                                  // [33:18] compare_written, [39:34] 0
    output logic                  m_axis_tuser    // [0] write_ignored
);

    t_cfg cfg;

    logic               r_in_valid;
    logic [ACT_W-1:0]   r_action;
    logic               r_sel;
    logic [FIELD_W-1:0] r_duty;
    logic [FIELD_W-1:0] r_period;
    logic               advance;

    logic               pwm_a, pwm_b, write_ignored;
    logic [FIELD_W-1:0] counter_value, compare_written;

    pwmg_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    assign s_axis_tready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action <= s_axis_tuser[1:0];
            r_sel    <= s_axis_tuser[2];
            r_duty   <= s_axis_tdata[15:0];
            r_period <= s_axis_tdata[31:16];
        end
    end

    pwmg_gen #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_gen (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (r_in_valid),
        .i_action         (r_action),
        .i_output_select  (r_sel),
        .i_duty           (r_duty),
        .i_period         (r_period),
        .o_advance        (advance),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_pwm_a          (pwm_a),
        .o_pwm_b          (pwm_b),
        .o_counter_value  (counter_value),
        .o_compare_written(compare_written),
        .o_write_ignored  (write_ignored)
    );

    assign m_axis_tdata = {6'd0, compare_written, counter_value, pwm_b, pwm_a};
    assign m_axis_tuser = write_ignored;

endmodule
